// ===== design/dhkom_pkg.sv =====
// ----------------------------------------------------------------------------
// dhkom_pkg
// Shared types and constants for the double-hash key/offset map.
// ----------------------------------------------------------------------------
package dhkom_pkg;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned VAL_W    = 64;
	localparam int unsigned STATUS_W = 3;

	localparam int unsigned         DEF_TABLE_SLOTS = 256;
	localparam logic [KEY_W-1:0]    DEF_EMPTY_KEY   = '0;

	// hash multipliers, products wrap at 32 bits
	localparam logic [KEY_W-1:0] HOME_MULT = 32'd2654435761;
	localparam logic [KEY_W-1:0] STEP_MULT = 32'd1099273;
	localparam logic [8:0]       STEP_MOD  = 9'd255;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_FOUND    = 3'd3,
		ST_MISSING  = 3'd4,
		ST_REJECTED = 3'd5
	} dhkom_status_t;

	typedef struct packed {
		logic              cmd;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value_in;
	} dhkom_req_t;

	typedef struct packed {
		dhkom_status_t     status;
		logic [VAL_W-1:0]  value_out;
	} dhkom_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic load_hash;
		logic load_probe;
		logic advance;
		logic clear_wr;
		logic commit;
		logic reject;
	} dhkom_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic key_empty;
		logic done;
		logic clear_last;
	} dhkom_stat_t;

endpackage

// ===== design/double_hash_key_offset_map.sv =====
// ----------------------------------------------------------------------------
// double_hash_key_offset_map
// Hash map of 32-bit keys to 64-bit offsets, open addressing, double hashing.
// ----------------------------------------------------------------------------
// Usage:
//   req (cmd, key, value_in) and rsp (status, value_out) are valid/ready
//   channels; one response per request transaction, in request order.
//   cmd 0 inserts or updates, cmd 1 looks up. A key equal to EMPTY_KEY is
//   rejected without touching the table.
//   After arst_n is released the key store is swept to EMPTY_KEY, one slot
//   per cycle; req_ready stays low until the sweep is done.
//   Each request probes P slots (1 .. TABLE_SLOTS); a rejected key probes
//   none. Each probe has two steps: address into the key RAM, then
//   registered read data compared. req_ready returns together with
//   rsp_valid once the result is registered, so one request is in flight at
//   a time and a new request is not taken until the result of the last one
//   is registered.
//   The response sits in an output register; a new request is taken while
//   it waits. If the receiver stalls, the next request stops at its final
//   compare (or its reject step) until the previous response is taken.
// ----------------------------------------------------------------------------
module double_hash_key_offset_map import dhkom_pkg::*; #(
	parameter int unsigned      TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter logic [KEY_W-1:0] EMPTY_KEY   = DEF_EMPTY_KEY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  dhkom_req_t req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output dhkom_rsp_t rsp
);

	dhkom_ctl_t  ctl;
	dhkom_stat_t stat;

	dhkom_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	dhkom_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.EMPTY_KEY   (EMPTY_KEY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ===== design/dhkom_ram.sv =====
// ----------------------------------------------------------------------------
// dhkom_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dhkom_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/dhkom_dp.sv =====
// ----------------------------------------------------------------------------
// dhkom_dp
// Datapath: hash units, probe address walk, key/value stores, result register.
// ----------------------------------------------------------------------------
module dhkom_dp import dhkom_pkg::*; #(
	parameter int unsigned      TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter logic [KEY_W-1:0] EMPTY_KEY   = DEF_EMPTY_KEY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dhkom_req_t  req,
	input  dhkom_ctl_t  ctl,
	output dhkom_stat_t stat,
	output dhkom_rsp_t  rsp
);

	localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
	localparam int unsigned SUM_W = (IDX_W > 8) ? IDX_W : 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [KEY_W-1:0] home_hash_q;
	logic [KEY_W-1:0] step_hash_q;
	logic [7:0]       step_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] clr_q;
	dhkom_rsp_t       rsp_q;

	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic             key_free;
	logic             key_hit;

	// step = (1 + h mod 255) | 1; mod 255 by folding bytes (256 == 1 mod 255)
	logic [9:0]       fold_sum;
	logic [8:0]       fold_red;
	logic [7:0]       fold_rem;
	logic [7:0]       step_next;
	logic [SUM_W-1:0] slot_sum;

	always_comb begin
		fold_sum  = 10'(step_hash_q[7:0]) + 10'(step_hash_q[15:8])
		          + 10'(step_hash_q[23:16]) + 10'(step_hash_q[31:24]);
		fold_red  = 9'(fold_sum[9:8]) + 9'(fold_sum[7:0]);
		fold_rem  = (fold_red >= STEP_MOD) ? 8'(fold_red - STEP_MOD) : fold_red[7:0];
		step_next = (fold_rem + 8'd1) | 8'd1;
		slot_sum  = SUM_W'(slot_q) + SUM_W'(step_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			op_q  <= req.cmd;
			key_q <= req.key;
			val_q <= req.value_in;
		end
		if (ctl.load_hash) begin
			home_hash_q <= key_q * HOME_MULT;
			step_hash_q <= key_q * STEP_MULT;
		end
		if (ctl.load_probe) begin
			step_q <= step_next;
			slot_q <= home_hash_q[IDX_W-1:0];
			cnt_q  <= '0;
		end else if (ctl.advance) begin
			slot_q <= slot_sum[IDX_W-1:0];
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign key_free = (rd_key == EMPTY_KEY);
	assign key_hit  = (rd_key == key_q);

	assign stat.key_empty  = (key_q == EMPTY_KEY);
	assign stat.done       = key_free || key_hit || (cnt_q == LAST_IDX);
	assign stat.clear_last = (clr_q == LAST_IDX);

	logic ins_commit;
	logic key_we;
	logic val_we;

	assign ins_commit = ctl.commit && !ctl.reject && (op_q == CMD_INSERT);
	assign key_we     = ctl.clear_wr || (ins_commit && key_free);
	assign val_we     = ins_commit && (key_free || key_hit);

	dhkom_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (ctl.clear_wr ? clr_q : slot_q),
		.wdata (ctl.clear_wr ? EMPTY_KEY : key_q),
		.raddr (slot_q),
		.rdata (rd_key)
	);

	dhkom_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_SLOTS)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (slot_q),
		.wdata (val_q),
		.raddr (slot_q),
		.rdata (rd_val)
	);

	dhkom_rsp_t rsp_next;

	always_comb begin
		rsp_next.value_out = '0;
		if (ctl.reject) begin
			rsp_next.status = ST_REJECTED;
		end else if (op_q == CMD_INSERT) begin
			if (key_free) begin
				rsp_next.status = ST_INSERTED;
			end else if (key_hit) begin
				rsp_next.status = ST_UPDATED;
			end else begin
				rsp_next.status = ST_FULL;
			end
		end else if (key_hit) begin
			rsp_next.status    = ST_FOUND;
			rsp_next.value_out = rd_val;
		end else begin
			rsp_next.status = ST_MISSING;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== design/dhkom_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhkom_ctrl
// Controller: table clear after reset, hash sequencing, probe loop, handshakes.
// ----------------------------------------------------------------------------
module dhkom_ctrl import dhkom_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output dhkom_ctl_t  ctl,
	input  dhkom_stat_t stat
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_STEP,
		S_READ,
		S_CMP,
		S_REJECT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_CLEAR:  ctl.clear_wr   = 1'b1;
			S_IDLE:   ctl.load_req   = req_valid;
			S_HASH:   ctl.load_hash  = 1'b1;
			S_STEP:   ctl.load_probe = 1'b1;
			S_READ:   ;
			S_CMP: begin
				if (!stat.done) begin
					ctl.advance = 1'b1;
				end else if (out_free) begin
					ctl.commit = 1'b1;
				end
			end
			S_REJECT: begin
				ctl.commit = out_free;
				ctl.reject = out_free;
			end
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_HASH;
					end
				end
				S_HASH:   state_q <= stat.key_empty ? S_REJECT : S_STEP;
				S_STEP:   state_q <= S_READ;
				S_READ:   state_q <= S_CMP;
				S_CMP: begin
					if (!stat.done) begin
						state_q <= S_READ;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_REJECT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_CLEAR;
			endcase

			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a result never overwrites one that has not been taken
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!out_valid_q || rsp_ready))
		else $error("result committed over a pending response");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> rsp_valid)
		else $error("committed result not presented");

	a_advance_open: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |-> !stat.done)
		else $error("probe advanced past a terminating slot");

	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear_wr |-> (!req_ready && !ctl.commit))
		else $error("transaction activity during table clear");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-hash key/offset map. Requests go in
// through bursts with random gaps while the response side stalls on its own
// pattern. A scoreboard keeps a shadow table, predicts every response from
// the accepted request stream and compares results in order. The run moves
// from an empty table through moderate load to a completely full table.
// ----------------------------------------------------------------------------
module tb;
	import dhkom_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	localparam int unsigned TAIL_CYCLES = 2 * DEF_TABLE_SLOTS + 100;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	class map_scoreboard;
		logic [KEY_W-1:0] slot_key [DEF_TABLE_SLOTS];
		logic [VAL_W-1:0] slot_val [DEF_TABLE_SLOTS];
		dhkom_rsp_t       pending[$];
		int unsigned      occupied;
		int unsigned      checked;
		int unsigned      errors;
		int unsigned      tally [6];

		function new();
			foreach (slot_key[i]) begin
				slot_key[i] = DEF_EMPTY_KEY;
				slot_val[i] = '0;
			end
			foreach (tally[i])
				tally[i] = 0;
			occupied = 0;
			checked  = 0;
			errors   = 0;
		endfunction

		// run the probe sequence on the shadow table, queue the expected response
		function void note(dhkom_req_t r);
			logic [KEY_W-1:0] home_h, step_h;
			int unsigned      home, step, slot;
			dhkom_rsp_t       e;
			e.value_out = '0;
			if (r.key == DEF_EMPTY_KEY) begin
				e.status = ST_REJECTED;
			end else begin
				home_h   = r.key * HOME_MULT;
				step_h   = r.key * STEP_MULT;
				home     = home_h % DEF_TABLE_SLOTS;
				step     = (1 + step_h % STEP_MOD) | 1;
				e.status = (r.cmd == CMD_INSERT) ? ST_FULL : ST_MISSING;
				for (int unsigned i = 0; i < DEF_TABLE_SLOTS; i++) begin
					slot = (home + i * step) % DEF_TABLE_SLOTS;
					if (slot_key[slot] == DEF_EMPTY_KEY) begin
						if (r.cmd == CMD_INSERT) begin
							slot_key[slot] = r.key;
							slot_val[slot] = r.value_in;
							occupied++;
							e.status = ST_INSERTED;
						end else begin
							e.status = ST_MISSING;
						end
						break;
					end
					if (slot_key[slot] == r.key) begin
						if (r.cmd == CMD_INSERT) begin
							slot_val[slot] = r.value_in;
							e.status = ST_UPDATED;
						end else begin
							e.value_out = slot_val[slot];
							e.status = ST_FOUND;
						end
						break;
					end
				end
			end
			tally[e.status]++;
			pending.push_back(e);
		endfunction

		function void check(dhkom_rsp_t got);
			dhkom_rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response: status %0d value %h",
						got.status, got.value_out);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.status !== e.status || got.value_out !== e.value_out) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch on response %0d: expected status %0d value %h,",
						" got status %0d value %h"},
						checked, e.status, e.value_out, got.status, got.value_out);
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	dhkom_req_t req       = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	dhkom_rsp_t rsp;

	map_scoreboard    sb = new();
	logic [KEY_W-1:0] known_keys[$];
	int unsigned      burst_left  = 0;
	int unsigned      n_sent      = 0;
	int unsigned      cycle_count = 0;

	double_hash_key_offset_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, sb.pending.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_ready)
			sb.check(rsp);
	end

	// response side back-pressure, switching between randomly chosen modes
	initial begin
		rx_mode_t    mode;
		int unsigned span;
		int unsigned beat;
		beat = 0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(32, 256);
			repeat (span) begin
				@(negedge clk);
				beat++;
				case (mode)
					RX_FREE:  rsp_ready <= 1'b1;
					RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
					RX_HEAVY: rsp_ready <= ($urandom_range(0, 7) == 0);
					RX_BEAT:  rsp_ready <= (beat % 3 == 0);
					default:  rsp_ready <= 1'b1;
				endcase
			end
		end
	end

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		do k = $urandom; while (k == DEF_EMPTY_KEY);
		// shared low byte means shared home slot: builds long probe chains
		if ($urandom_range(0, 7) == 0)
			k[7:0] = 8'h5A;
		return k;
	endfunction

	function automatic logic [VAL_W-1:0] any_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// called and returns at a falling edge; valid stays up across back-to-back transactions
	task automatic send_item(input logic c, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		dhkom_req_t  r;
		int unsigned gap;
		r.cmd      = c;
		r.key      = k;
		r.value_in = v;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note(r);
		n_sent++;
		if (c == CMD_INSERT && k != DEF_EMPTY_KEY)
			known_keys.push_back(k);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid  <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_ops(input int unsigned count);
		logic             c;
		logic [KEY_W-1:0] k;
		int unsigned      pick;
		repeat (count) begin
			c    = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_LOOKUP;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				k = DEF_EMPTY_KEY;
			else if (pick < 30 || known_keys.size() == 0)
				k = fresh_key();
			else
				k = known_keys[$urandom_range(0, known_keys.size() - 1)];
			send_item(c, k, any_value());
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, value extremes, updates, rejected key, collisions
		send_item(CMD_LOOKUP, 32'h1234_5678, any_value());
		send_item(CMD_INSERT, 32'hFFFF_FFFF, '1);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
		send_item(CMD_INSERT, 32'h0000_0001, '0);
		send_item(CMD_LOOKUP, 32'h0000_0001, '1);
		send_item(CMD_INSERT, 32'h0000_0001, 64'h8000_0000_0000_0001);
		send_item(CMD_LOOKUP, 32'h0000_0001, '0);
		send_item(CMD_INSERT, DEF_EMPTY_KEY, '1);
		send_item(CMD_LOOKUP, DEF_EMPTY_KEY, '0);
		// low byte zero: all land on the same home slot
		send_item(CMD_INSERT, 32'h0000_0100, 64'hA5A5_A5A5_A5A5_A5A5);
		send_item(CMD_INSERT, 32'h0000_0200, 64'h5A5A_5A5A_5A5A_5A5A);
		send_item(CMD_INSERT, 32'h0000_0300, 64'h0123_4567_89AB_CDEF);
		send_item(CMD_INSERT, 32'h8000_0000, 64'hFEDC_BA98_7654_3210);
		send_item(CMD_LOOKUP, 32'h0000_0300, '0);
		send_item(CMD_LOOKUP, 32'h8000_0000, '0);
		send_item(CMD_LOOKUP, 32'h0000_0400, '0);
		send_item(CMD_INSERT, 32'h0000_0200, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(CMD_LOOKUP, 32'h0000_0200, '0);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFE, '0);
		send_item(CMD_INSERT, 32'h7FFF_FFFF, 64'h0000_0000_FFFF_FFFF);
		send_item(CMD_LOOKUP, 32'h7FFF_FFFF, '0);
		drain();

		// moderate load: repeated keys mixed with new ones
		random_ops(1000);
		drain();

		// fill every slot, then exercise full-table inserts and exhausted lookups
		while (sb.occupied < DEF_TABLE_SLOTS)
			send_item(CMD_INSERT, fresh_key(), any_value());
		drain();
		random_ops(550);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.errors++;
			$display("%0d expected responses never arrived", sb.pending.size());
		end
		$display("%0d requests (%0d inserted, %0d updated, %0d full, %0d found, %0d missing,",
			n_sent, sb.tally[ST_INSERTED], sb.tally[ST_UPDATED], sb.tally[ST_FULL],
			sb.tally[ST_FOUND], sb.tally[ST_MISSING]);
		$display("%0d rejected), %0d responses checked, %0d errors, %0d cycles",
			sb.tally[ST_REJECTED], sb.checked, sb.errors, cycle_count);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
